FILE: sv/psca_pkg.sv
package psca_pkg;

    // table geometry
    localparam int CELL_COUNT = 64;
    localparam int OWNER_BITS = 8;

    // field widths fixed by the interface
    localparam int SIZE_W  = 7;
    localparam int OWNER_W = 8;
    localparam int FIRST_W = 6;

    // derived widths
    localparam int IDX_W = $clog2(CELL_COUNT);
    localparam int CNT_W = $clog2(CELL_COUNT + 1);
    localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    typedef enum logic
    {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic
    {
        MODE_PAGED   = 1'b0,
        MODE_SCATTER = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        STAT_GRANTED  = 2'd0,
        STAT_BLOCKED  = 2'd1,
        STAT_RELEASED = 2'd2
    } status_t;

    // sweep packet handed from cell to cell
    typedef struct packed
    {
        logic                  valid;
        logic                  wr_phase;
        op_t                   op;
        mode_t                 mode;
        logic [OWNER_BITS-1:0] owner;
        logic [CMP_W-1:0]      size;
        logic [CMP_W-1:0]      span;
        logic [CMP_W-1:0]      run;
        logic [CMP_W-1:0]      first;
        logic                  found;
        logic                  seen;
    } cell_pkt_t;

endpackage

FILE: sv/psca_cell.sv
module psca_cell
    import psca_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  cell_pkt_t        pkt_in,
    output cell_pkt_t        pkt_out
);

    logic                  used_reg;
    logic                  used_next;
    logic [OWNER_BITS-1:0] owner_reg;
    logic [OWNER_BITS-1:0] owner_next;
    cell_pkt_t             pkt_reg;
    cell_pkt_t             pkt_next;

    // per-cell step of the sweep
    always_comb
    begin
        logic [CMP_W-1:0] idx_ext;
        logic [CMP_W-1:0] run_inc;
        logic             in_range;
        logic             take;

        idx_ext    = CMP_W'(cell_idx);
        run_inc    = pkt_in.run + CMP_W'(1);
        in_range   = pkt_in.valid && (idx_ext < pkt_in.span);
        take       = 1'b0;
        used_next  = used_reg;
        owner_next = owner_reg;
        pkt_next   = pkt_in;

        if (in_range)
        begin
            if (pkt_in.op == OP_RELEASE)
            begin
                // free every cell of this owner within the covered range
                if (used_reg && (owner_reg == pkt_in.owner))
                begin
                    used_next = 1'b0;
                end
            end
            else if (pkt_in.wr_phase)
            begin
                // claim pass
                if (pkt_in.mode == MODE_SCATTER)
                begin
                    take = !used_reg;
                end
                else
                begin
                    take = (idx_ext >= pkt_in.first);
                end
                if (take && (pkt_in.run < pkt_in.size))
                begin
                    used_next    = 1'b1;
                    owner_next   = pkt_in.owner;
                    pkt_next.run = run_inc;
                end
            end
            else if (!pkt_in.found)
            begin
                // search pass
                if (pkt_in.mode == MODE_SCATTER)
                begin
                    if (!used_reg)
                    begin
                        if (!pkt_in.seen)
                        begin
                            pkt_next.first = idx_ext;
                            pkt_next.seen  = 1'b1;
                        end
                        pkt_next.run = run_inc;
                        if (run_inc == pkt_in.size)
                        begin
                            pkt_next.found = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (!used_reg)
                    begin
                        pkt_next.run = run_inc;
                        if (run_inc == pkt_in.size)
                        begin
                            pkt_next.found = 1'b1;
                        end
                    end
                    else
                    begin
                        pkt_next.first = idx_ext + CMP_W'(1);
                        pkt_next.run   = '0;
                    end
                end
            end
        end
    end

    // cell state and packet register, only cell state and the packet's valid bit are reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= 1'b0;
            pkt_reg.valid <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            pkt_reg  <= pkt_next;
        end
    end

    // owner needs no reset
    always_ff @(posedge clk)
    begin
        owner_reg <= owner_next;
    end

    assign pkt_out = pkt_reg;

endmodule

FILE: sv/paged_segmented_cell_allocator_top.sv
// Paged / segmented cell allocator.
// Command channel: an allocate or release transaction is taken at a clock
// edge with start high and busy low; operation, owner_id and request_size
// are sampled at that edge. busy stays high until the result is out.
// Result channel: done is high for exactly one cycle with status and
// first_cell valid; the receiver cannot stall it.
// Configuration: APB-style port, placement_mode at 0x0, cells_in_use at
// 0x4; written only while busy is low (the block does not enforce this). pready is always high.
// Timing: a packet sweeps a row of CELL_COUNT cells, one cell per cycle.
// A release or a blocked allocate makes one sweep from start to done. A
// granted allocate sweeps once to search and once to claim. busy drops
// with done, so the next transaction can be taken at the edge that ends done.
// Reset: every cell free, placement_mode paged, cells_in_use 64, no
// transaction in flight.
module paged_segmented_cell_allocator_top
    import psca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic [OWNER_W-1:0] owner_id,
    input  logic [SIZE_W-1:0]  request_size,
    output logic               done,
    output logic [1:0]         status,
    output logic [FIRST_W-1:0] first_cell
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SEARCH,
        ST_WRITE
    } state_t;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_CELLS = 1'b1;

    state_t             state_reg;
    mode_t              mode_reg;
    logic [SIZE_W-1:0]  cells_reg;
    cell_pkt_t          inject_reg;
    cell_pkt_t          claim_pkt;
    logic               done_reg;
    status_t            status_reg;
    logic [FIRST_W-1:0] first_reg;
    logic [CMP_W-1:0]   span_next;
    logic [CMP_W-1:0]   cells_ext;
    logic               cfg_wr;
    logic               accept;
    cell_pkt_t          chain [CELL_COUNT+1];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PAGED;
            cells_reg <= SIZE_W'(64);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_MODE:  mode_reg  <= mode_t'(pwdata[0]);
                REG_CELLS: cells_reg <= pwdata[SIZE_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_MODE:  prdata = 32'(mode_reg);
            REG_CELLS: prdata = 32'(cells_reg);
            default:   prdata = '0;
        endcase
    end

    // covered range, clamped to the table
    assign cells_ext = CMP_W'(cells_reg);
    assign span_next = (cells_ext > CMP_W'(CELL_COUNT)) ? CMP_W'(CELL_COUNT) : cells_ext;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // row of cells
    assign chain[0] = inject_reg;

    for (genvar g = 0; g < CELL_COUNT; g++)
    begin : g_cell
        psca_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (IDX_W'(g)),
            .pkt_in   (chain[g]),
            .pkt_out  (chain[g+1])
        );
    end

    // packet for the claim pass, rebuilt from the search result
    always_comb
    begin
        claim_pkt          = chain[CELL_COUNT];
        claim_pkt.wr_phase = 1'b1;
        claim_pkt.run      = '0;
    end

    // sequencer: inject sweeps and collect the packet at the end of the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            inject_reg.valid <= 1'b0;
            done_reg         <= 1'b0;
            status_reg       <= STAT_BLOCKED;
            first_reg        <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (accept)
                    begin
                        inject_reg.valid    <= 1'b1;
                        inject_reg.wr_phase <= 1'b0;
                        inject_reg.op       <= op_t'(operation);
                        inject_reg.mode     <= mode_reg;
                        inject_reg.owner    <= OWNER_BITS'(owner_id);
                        inject_reg.size     <= CMP_W'(request_size);
                        inject_reg.span     <= span_next;
                        inject_reg.run      <= '0;
                        inject_reg.first    <= '0;
                        inject_reg.found    <= 1'b0;
                        inject_reg.seen     <= 1'b0;
                        state_reg           <= ST_SEARCH;
                    end
                    else
                    begin
                        inject_reg.valid <= 1'b0;
                    end
                end
                ST_SEARCH:
                begin
                    if (chain[CELL_COUNT].valid)
                    begin
                        if (chain[CELL_COUNT].op == OP_RELEASE)
                        begin
                            inject_reg.valid <= 1'b0;
                            done_reg         <= 1'b1;
                            status_reg       <= STAT_RELEASED;
                            first_reg        <= '0;
                            state_reg        <= ST_IDLE;
                        end
                        else if (chain[CELL_COUNT].found)
                        begin
                            inject_reg <= claim_pkt;
                            done_reg   <= 1'b0;
                            state_reg  <= ST_WRITE;
                        end
                        else
                        begin
                            inject_reg.valid <= 1'b0;
                            done_reg         <= 1'b1;
                            status_reg       <= STAT_BLOCKED;
                            first_reg        <= '0;
                            state_reg        <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        inject_reg.valid <= 1'b0;
                        done_reg         <= 1'b0;
                    end
                end
                ST_WRITE:
                begin
                    inject_reg.valid <= 1'b0;
                    if (chain[CELL_COUNT].valid)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= STAT_GRANTED;
                        first_reg  <= chain[CELL_COUNT].first[FIRST_W-1:0];
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                    end
                end
                default:
                begin
                    inject_reg.valid <= 1'b0;
                    done_reg         <= 1'b0;
                    state_reg        <= ST_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign first_cell = first_reg;

endmodule
